// ----- rtl/i2cm_pkg.sv -----
// Package for the I2C master with retry: phase codes, opcodes, status codes
// and register reset values. No dependencies.
`timescale 1ns / 1ps
package i2cm_pkg;
  localparam int MAX_LEN_DEF = 16;

  localparam logic [1:0] OP_TICK  = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_START = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FAILED  = 2'd1;
  localparam logic [1:0] ST_REFUSED = 2'd2;

  localparam logic [1:0] REG_DELAY   = 2'd0;
  localparam logic [1:0] REG_WAIT    = 2'd1;
  localparam logic [1:0] REG_RETRY   = 2'd2;
  localparam logic [1:0] REG_RECOVER = 2'd3;

  localparam logic [3:0] DELAY_RST   = 4'd5;
  localparam logic [9:0] WAIT_RST    = 10'd1000;
  localparam logic [3:0] RETRY_RST   = 4'd8;
  localparam logic [4:0] RECOVER_RST = 5'd16;

  typedef enum logic [4:0] {
    PH_IDLE, PH_CHK_SDA, PH_W_SDA_HI, PH_CHK_SCL, PH_W_SCL_HI, PH_ST_PAUSE,
    PH_W_BIT_SCL_LO, PH_W_BIT_SDA, PH_W_BIT_SCL_HI, PH_W_BYTE_SCL_LO,
    PH_CHK_ACK_SCL, PH_W_ACK_SCL_LO, PH_ACK_PAUSE, PH_W_ACK_SDA,
    PH_W_ACK_SCL_END, PH_RD_PAUSE0, PH_RD_BIT_PAUSE, PH_W_RD_SCL_HI,
    PH_RD_P1, PH_RD_P2, PH_RD_P3, PH_RD_P4, PH_CHK_STOP_SCL,
    PH_W_STOP_SCL_LO, PH_STOP_P1, PH_W_STOP_SCL_HI, PH_STOP_P2,
    PH_W_STOP_SDA_HI, PH_REC_P1, PH_REC_P2, PH_W_REC_SDA
  } phase_t;

  typedef struct packed {
    logic [3:0] delay_ticks;
    logic [9:0] wait_limit;
    logic [3:0] retry_limit;
    logic [4:0] recovery_pulses;
  } cfg_t;
endpackage

// ----- rtl/i2cm_ram.sv -----
// Generic single-port-write, registered-read RAM.
// No dependencies.
`timescale 1ns / 1ps
module i2cm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/i2c_master_with_retry.sv -----
// Top level of the tick-stepped I2C master with retry and bus recovery.
// Depends on i2cm_pkg and i2cm_ram.
`timescale 1ns / 1ps
// Usage: each input word is a tick (line samples), a write-byte load or a
// start command; each accepted word yields exactly one result word with the
// SCL/SDA drive levels, an optional read byte, done/status and busy.
// Input words are registered, then processed by one combinational step into
// the result register, which drives out_valid; a new word is taken every
// cycle while the result side takes words. The write buffer is a small RAM
// with registered read; it reads the entry at the next byte position every
// cycle, so the byte to send is already on its read port when a send
// begins.
// When out_stall is high the result register holds and the input register
// fills; in_stall rises only while both are full.
// Reset: config and controller registers return to their defaults, the controller is idle with
// both lines released; the write buffer contents are undefined until loaded.
module i2c_master_with_retry #(
  parameter int MAX_LEN = i2cm_pkg::MAX_LEN_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [9:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_opcode,
  input  logic       in_scl_in,
  input  logic       in_sda_in,
  input  logic [7:0] in_data_byte,
  input  logic [6:0] in_dev_addr,
  input  logic       in_read_not_write,
  input  logic [4:0] in_length,
  input  logic       in_keep_bus,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_scl_drive,
  output logic       out_sda_drive,
  output logic [7:0] out_read_byte,
  output logic       out_read_valid,
  output logic [3:0] out_read_index,
  output logic       out_done_res,
  output logic [1:0] out_status,
  output logic       out_busy_res
);
  localparam int AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int CW = $clog2(MAX_LEN + 1);
  localparam int LW = (CW > 5) ? CW : 5;
  localparam logic [LW-1:0] MAXL = LW'(MAX_LEN);

  i2cm_pkg::cfg_t cfg_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.delay_ticks     <= i2cm_pkg::DELAY_RST;
      cfg_r.wait_limit      <= i2cm_pkg::WAIT_RST;
      cfg_r.retry_limit     <= i2cm_pkg::RETRY_RST;
      cfg_r.recovery_pulses <= i2cm_pkg::RECOVER_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        i2cm_pkg::REG_DELAY:   cfg_r.delay_ticks     <= cfg_data[3:0];
        i2cm_pkg::REG_WAIT:    cfg_r.wait_limit      <= cfg_data;
        i2cm_pkg::REG_RETRY:   cfg_r.retry_limit     <= cfg_data[3:0];
        i2cm_pkg::REG_RECOVER: cfg_r.recovery_pulses <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // input register
  logic       iv_r;
  logic [1:0] op_r;
  logic       scl_r, sda_r, rnw_r, keep_r;
  logic [7:0] dbyte_r;
  logic [6:0] addr_r;
  logic [4:0] len_r;
  logic       ov_r;
  logic       adv;

  assign adv      = iv_r && (!ov_r || !out_stall);
  assign in_stall = iv_r && !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      iv_r <= 1'b1;
    end else if (adv) begin
      iv_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      op_r    <= in_opcode;
      scl_r   <= in_scl_in;
      sda_r   <= in_sda_in;
      dbyte_r <= in_data_byte;
      addr_r  <= in_dev_addr;
      rnw_r   <= in_read_not_write;
      len_r   <= in_length;
      keep_r  <= in_keep_bus;
    end
  end

  // controller state
  i2cm_pkg::phase_t phase_r, phase_nxt;
  logic [CW-1:0] load_r, load_nxt;
  logic [7:0]    shift_r, shift_nxt;
  logic [3:0]    bitc_r, bitc_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic [9:0]    waitc_r, waitc_nxt;
  logic [3:0]    pausec_r, pausec_nxt;
  logic [3:0]    att_r, att_nxt;
  logic [4:0]    pulse_r, pulse_nxt;
  logic [6:0]    caddr_r, caddr_nxt;
  logic          crd_r, crd_nxt, ckeep_r, ckeep_nxt;
  logic [LW-1:0] clen_r, clen_nxt;
  logic          dscl_r, dscl_nxt, dsda_r, dsda_nxt;
  logic          fail_r, fail_nxt;

  logic          r_done, r_valid;
  logic [1:0]    r_status;
  logic [7:0]    r_byte;
  logic [3:0]    r_index;

  // write buffer with prefetch of entry pos_nxt
  logic          ram_we;
  logic [7:0]    ram_rdata;
  logic [AW-1:0] ram_raddr;

  assign ram_we    = adv && op_r == i2cm_pkg::OP_LOAD && phase_r == i2cm_pkg::PH_IDLE
                     && load_r < CW'(MAX_LEN);
  assign ram_raddr = AW'(pos_nxt);

  i2cm_ram #(.WIDTH(8), .DEPTH(MAX_LEN)) u_wbuf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (AW'(load_r)),
    .wdata (dbyte_r),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  logic pause_done;
  logic [3:0] pause_inc;
  logic wait_act, wait_val, wait_smp;
  logic [1:0] wres;
  logic [9:0] waitc_inc;

  always_comb begin
    pause_inc  = pausec_r + 4'd1;
    pause_done = pause_inc >= cfg_r.delay_ticks;
    waitc_inc  = waitc_r + 10'd1;
  end

  // wait_step as a function of sample/value
  function automatic logic [1:0] wstep(input logic s, input logic v,
                                       input logic [3:0] pc, input logic [3:0] dt,
                                       input logic [9:0] wi, input logic [9:0] wl);
    logic [1:0] r;
    begin
      if (pc < dt) r = 2'd0;
      else if (s == v) r = 2'd1;
      else if (wi >= wl) r = 2'd2;
      else r = 2'd0;
      return r;
    end
  endfunction

  logic bitv;
  logic [LW-1:0] pos_ext, pos1;
  logic [3:0] att_inc;

  always_comb begin
    phase_nxt  = phase_r;
    load_nxt   = load_r;
    shift_nxt  = shift_r;
    bitc_nxt   = bitc_r;
    pos_nxt    = pos_r;
    waitc_nxt  = waitc_r;
    pausec_nxt = pausec_r;
    att_nxt    = att_r;
    pulse_nxt  = pulse_r;
    caddr_nxt  = caddr_r;
    crd_nxt    = crd_r;
    ckeep_nxt  = ckeep_r;
    clen_nxt   = clen_r;
    dscl_nxt   = dscl_r;
    dsda_nxt   = dsda_r;
    fail_nxt   = fail_r;
    r_done     = 1'b0;
    r_status   = i2cm_pkg::ST_OK;
    r_valid    = 1'b0;
    r_byte     = 8'd0;
    r_index    = 4'd0;
    bitv       = shift_r[7];
    pos_ext    = LW'(pos_r);
    pos1       = pos_ext + LW'(1);
    att_inc    = att_r + 4'd1;
    wait_act   = 1'b0;
    wait_val   = 1'b0;
    wait_smp   = 1'b0;
    wres       = 2'd0;

    // generic wait-step bookkeeping
    case (phase_r)
      i2cm_pkg::PH_W_SDA_HI, i2cm_pkg::PH_W_STOP_SDA_HI,
      i2cm_pkg::PH_W_REC_SDA: begin
        wait_act = 1'b1; wait_smp = sda_r; wait_val = 1'b1;
      end
      i2cm_pkg::PH_W_BIT_SDA: begin
        wait_act = 1'b1; wait_smp = sda_r; wait_val = bitv;
      end
      i2cm_pkg::PH_W_ACK_SDA: begin
        wait_act = 1'b1; wait_smp = sda_r; wait_val = 1'b0;
      end
      i2cm_pkg::PH_W_SCL_HI, i2cm_pkg::PH_W_BIT_SCL_HI, i2cm_pkg::PH_W_RD_SCL_HI,
      i2cm_pkg::PH_W_STOP_SCL_HI: begin
        wait_act = 1'b1; wait_smp = scl_r; wait_val = 1'b1;
      end
      i2cm_pkg::PH_W_BIT_SCL_LO, i2cm_pkg::PH_W_BYTE_SCL_LO, i2cm_pkg::PH_W_ACK_SCL_LO,
      i2cm_pkg::PH_W_ACK_SCL_END, i2cm_pkg::PH_W_STOP_SCL_LO: begin
        wait_act = 1'b1; wait_smp = scl_r; wait_val = 1'b0;
      end
      default: ;
    endcase

    if (adv) begin
      case (op_r)
        i2cm_pkg::OP_TICK: begin
          if (phase_r != i2cm_pkg::PH_IDLE) begin
            if (wait_act) begin
              wres = wstep(wait_smp, wait_val, pausec_r, cfg_r.delay_ticks,
                           waitc_inc, cfg_r.wait_limit);
              if (pausec_r < cfg_r.delay_ticks) pausec_nxt = pause_inc;
              else if (wait_smp != wait_val) waitc_nxt = waitc_inc;
            end else begin
              pausec_nxt = pause_inc;
            end

            case (phase_r)
              i2cm_pkg::PH_CHK_SDA: begin
                if (!sda_r) begin dsda_nxt = 1'b1; phase_nxt = i2cm_pkg::PH_W_SDA_HI; end
                else phase_nxt = i2cm_pkg::PH_CHK_SCL;
              end
              i2cm_pkg::PH_W_SDA_HI: begin
                if (wres == 2'd1) phase_nxt = i2cm_pkg::PH_CHK_SCL;
                else if (wres == 2'd2) begin
                  fail_nxt = 1'b1; phase_nxt = i2cm_pkg::PH_CHK_STOP_SCL;
                end
              end
              i2cm_pkg::PH_CHK_SCL: begin
                if (!scl_r) begin dscl_nxt = 1'b1; phase_nxt = i2cm_pkg::PH_W_SCL_HI; end
                else begin dsda_nxt = 1'b0; phase_nxt = i2cm_pkg::PH_ST_PAUSE; end
              end
              i2cm_pkg::PH_W_SCL_HI: begin
                if (wres == 2'd1) begin
                  dsda_nxt = 1'b0; phase_nxt = i2cm_pkg::PH_ST_PAUSE;
                end else if (wres == 2'd2) begin
                  fail_nxt = 1'b1; phase_nxt = i2cm_pkg::PH_CHK_STOP_SCL;
                end
              end
              i2cm_pkg::PH_ST_PAUSE: begin
                if (pause_done) begin
                  shift_nxt = {caddr_r, crd_r}; bitc_nxt = 4'd0; dscl_nxt = 1'b0;
                  phase_nxt = i2cm_pkg::PH_W_BIT_SCL_LO;
                end
              end
              i2cm_pkg::PH_W_BIT_SCL_LO: begin
                if (wres == 2'd1) begin
                  dsda_nxt = bitv; phase_nxt = i2cm_pkg::PH_W_BIT_SDA;
                end else if (wres == 2'd2) begin
                  fail_nxt = 1'b1; phase_nxt = i2cm_pkg::PH_CHK_STOP_SCL;
                end
              end
              i2cm_pkg::PH_W_BIT_SDA: begin
                if (wres == 2'd1) begin
                  dscl_nxt = 1'b1; phase_nxt = i2cm_pkg::PH_W_BIT_SCL_HI;
                end else if (wres == 2'd2) begin
                  fail_nxt = 1'b1; phase_nxt = i2cm_pkg::PH_CHK_STOP_SCL;
                end
              end
              i2cm_pkg::PH_W_BIT_SCL_HI: begin
                if (wres == 2'd1) begin
                  shift_nxt = {shift_r[6:0], 1'b0};
                  bitc_nxt  = bitc_r + 4'd1;
                  dscl_nxt  = 1'b0;
                  phase_nxt = (bitc_r + 4'd1 < 4'd8) ? i2cm_pkg::PH_W_BIT_SCL_LO
                                                     : i2cm_pkg::PH_W_BYTE_SCL_LO;
                end else if (wres == 2'd2) begin
                  fail_nxt = 1'b1; phase_nxt = i2cm_pkg::PH_CHK_STOP_SCL;
                end
              end
              i2cm_pkg::PH_W_BYTE_SCL_LO: begin
                if (wres == 2'd1) phase_nxt = i2cm_pkg::PH_CHK_ACK_SCL;
                else if (wres == 2'd2) begin
                  fail_nxt = 1'b1; phase_nxt = i2cm_pkg::PH_CHK_STOP_SCL;
                end
              end
              i2cm_pkg::PH_CHK_ACK_SCL: begin
                if (scl_r) begin dscl_nxt = 1'b0; phase_nxt = i2cm_pkg::PH_W_ACK_SCL_LO; end
                else begin dsda_nxt = 1'b1; phase_nxt = i2cm_pkg::PH_ACK_PAUSE; end
              end
              i2cm_pkg::PH_W_ACK_SCL_LO: begin
                if (wres == 2'd1) begin
                  dsda_nxt = 1'b1; phase_nxt = i2cm_pkg::PH_ACK_PAUSE;
                end else if (wres == 2'd2) begin
                  fail_nxt = 1'b1; phase_nxt = i2cm_pkg::PH_CHK_STOP_SCL;
                end
              end
              i2cm_pkg::PH_ACK_PAUSE: begin
                if (pause_done) begin dscl_nxt = 1'b1; phase_nxt = i2cm_pkg::PH_W_ACK_SDA; end
              end
              i2cm_pkg::PH_W_ACK_SDA: begin
                if (wres != 2'd0) begin
                  if (wres == 2'd2) fail_nxt = 1'b1;
                  dscl_nxt = 1'b0; phase_nxt = i2cm_pkg::PH_W_ACK_SCL_END;
                end
              end
              i2cm_pkg::PH_W_ACK_SCL_END: begin
                if (wres != 2'd0) begin
                  if (wres == 2'd2 || fail_r) begin
                    fail_nxt = 1'b1; phase_nxt = i2cm_pkg::PH_CHK_STOP_SCL;
                  end else if (crd_r) begin
                    if (clen_r != '0) begin
                      dsda_nxt = 1'b1; bitc_nxt = 4'd0; shift_nxt = 8'd0;
                      phase_nxt = i2cm_pkg::PH_RD_PAUSE0;
                    end else phase_nxt = i2cm_pkg::PH_CHK_STOP_SCL;
                  end else if (pos_ext < clen_r) begin
                    pos_nxt   = pos_r + CW'(1);
                    shift_nxt = ram_rdata; bitc_nxt = 4'd0; dscl_nxt = 1'b0;
                    phase_nxt = i2cm_pkg::PH_W_BIT_SCL_LO;
                  end else if (ckeep_r) begin
                    phase_nxt = i2cm_pkg::PH_IDLE; r_done = 1'b1;
                  end else phase_nxt = i2cm_pkg::PH_CHK_STOP_SCL;
                end
              end
              i2cm_pkg::PH_RD_PAUSE0: begin
                if (pause_done) begin dscl_nxt = 1'b0; phase_nxt = i2cm_pkg::PH_RD_BIT_PAUSE; end
              end
              i2cm_pkg::PH_RD_BIT_PAUSE: begin
                if (pause_done) begin dscl_nxt = 1'b1; phase_nxt = i2cm_pkg::PH_W_RD_SCL_HI; end
              end
              i2cm_pkg::PH_W_RD_SCL_HI: begin
                wres = wstep(scl_r, 1'b1, pausec_r, cfg_r.delay_ticks,
                             waitc_inc, cfg_r.wait_limit);
                if (pausec_r < cfg_r.delay_ticks) pausec_nxt = pause_inc;
                else if (!scl_r) waitc_nxt = waitc_inc;
                if (wres == 2'd1) begin
                  shift_nxt = {shift_r[6:0], sda_r};
                  bitc_nxt  = bitc_r + 4'd1;
                  dscl_nxt  = 1'b0;
                  phase_nxt = (bitc_r + 4'd1 < 4'd8) ? i2cm_pkg::PH_RD_BIT_PAUSE
                                                     : i2cm_pkg::PH_RD_P1;
                end else if (wres == 2'd2) begin
                  fail_nxt = 1'b1; phase_nxt = i2cm_pkg::PH_CHK_STOP_SCL;
                end
              end
              i2cm_pkg::PH_RD_P1: begin
                if (pause_done) begin
                  dsda_nxt = (pos1 == clen_r); phase_nxt = i2cm_pkg::PH_RD_P2;
                end
              end
              i2cm_pkg::PH_RD_P2: begin
                if (pause_done) begin dscl_nxt = 1'b1; phase_nxt = i2cm_pkg::PH_RD_P3; end
              end
              i2cm_pkg::PH_RD_P3: begin
                if (pause_done) begin dscl_nxt = 1'b0; phase_nxt = i2cm_pkg::PH_RD_P4; end
              end
              i2cm_pkg::PH_RD_P4: begin
                if (pause_done) begin
                  r_valid = 1'b1; r_byte = shift_r; r_index = 4'(pos_r);
                  pos_nxt = pos_r + CW'(1);
                  if (pos1 < clen_r) begin
                    dsda_nxt = 1'b1; bitc_nxt = 4'd0; shift_nxt = 8'd0;
                    phase_nxt = i2cm_pkg::PH_RD_PAUSE0;
                  end else phase_nxt = i2cm_pkg::PH_CHK_STOP_SCL;
                end
              end
              i2cm_pkg::PH_CHK_STOP_SCL: begin
                if (scl_r) begin dscl_nxt = 1'b0; phase_nxt = i2cm_pkg::PH_W_STOP_SCL_LO; end
                else begin dsda_nxt = 1'b0; phase_nxt = i2cm_pkg::PH_STOP_P1; end
              end
              i2cm_pkg::PH_W_STOP_SCL_LO: begin
                if (wres != 2'd0) begin dsda_nxt = 1'b0; phase_nxt = i2cm_pkg::PH_STOP_P1; end
              end
              i2cm_pkg::PH_STOP_P1: begin
                if (pause_done) begin dscl_nxt = 1'b1; phase_nxt = i2cm_pkg::PH_W_STOP_SCL_HI; end
              end
              i2cm_pkg::PH_STOP_P2: begin
                if (pause_done) begin dsda_nxt = 1'b1; phase_nxt = i2cm_pkg::PH_W_STOP_SDA_HI; end
              end
              i2cm_pkg::PH_W_STOP_SDA_HI: begin
                if (wres == 2'd2) begin
                  pulse_nxt = 5'd0; dscl_nxt = 1'b0; phase_nxt = i2cm_pkg::PH_REC_P1;
                end
              end
              i2cm_pkg::PH_REC_P1: begin
                if (pause_done) begin dscl_nxt = 1'b1; phase_nxt = i2cm_pkg::PH_REC_P2; end
              end
              i2cm_pkg::PH_REC_P2: begin
                if (pause_done) begin
                  dsda_nxt  = 1'b1;
                  pulse_nxt = pulse_r + 5'd1;
                  if (pulse_r + 5'd1 < cfg_r.recovery_pulses && pulse_r != 5'd31) begin
                    dscl_nxt = 1'b0; phase_nxt = i2cm_pkg::PH_REC_P1;
                  end else phase_nxt = i2cm_pkg::PH_W_REC_SDA;
                end
              end
              default: ;
            endcase

            // stop end: finish the attempt
            if ((phase_r == i2cm_pkg::PH_W_STOP_SCL_HI && wres == 2'd2)
                || (phase_r == i2cm_pkg::PH_W_STOP_SDA_HI && wres == 2'd1)
                || (phase_r == i2cm_pkg::PH_W_REC_SDA && wres != 2'd0)) begin
              if (!fail_r) begin
                phase_nxt = i2cm_pkg::PH_IDLE; r_done = 1'b1;
              end else begin
                att_nxt = att_inc;
                if (att_inc >= cfg_r.retry_limit || att_inc == 4'd0) begin
                  phase_nxt = i2cm_pkg::PH_IDLE; r_done = 1'b1;
                  r_status  = i2cm_pkg::ST_FAILED;
                end else begin
                  fail_nxt = 1'b0; pos_nxt = '0; phase_nxt = i2cm_pkg::PH_CHK_SDA;
                end
              end
            end else if (phase_r == i2cm_pkg::PH_W_STOP_SCL_HI && wres == 2'd1) begin
              phase_nxt = i2cm_pkg::PH_STOP_P2;
            end

            if (phase_nxt != phase_r) begin
              pausec_nxt = 4'd0; waitc_nxt = 10'd0;
            end else if (phase_r == i2cm_pkg::PH_REC_P2 && pause_done) begin
              pausec_nxt = 4'd0; waitc_nxt = 10'd0;
            end
          end
        end
        i2cm_pkg::OP_LOAD: begin
          if (phase_r != i2cm_pkg::PH_IDLE) r_status = i2cm_pkg::ST_REFUSED;
          else if (load_r < CW'(MAX_LEN)) load_nxt = load_r + CW'(1);
        end
        i2cm_pkg::OP_START: begin
          if (phase_r != i2cm_pkg::PH_IDLE) r_status = i2cm_pkg::ST_REFUSED;
          else begin
            caddr_nxt  = addr_r;
            crd_nxt    = rnw_r;
            ckeep_nxt  = keep_r;
            clen_nxt   = (LW'(len_r) > MAXL) ? MAXL : LW'(len_r);
            load_nxt   = '0;
            att_nxt    = 4'd0;
            fail_nxt   = 1'b0;
            pos_nxt    = '0;
            pausec_nxt = 4'd0;
            waitc_nxt  = 10'd0;
            phase_nxt  = i2cm_pkg::PH_CHK_SDA;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= i2cm_pkg::PH_IDLE;
      load_r   <= '0;
      shift_r  <= 8'd0;
      bitc_r   <= 4'd0;
      pos_r    <= '0;
      waitc_r  <= 10'd0;
      pausec_r <= 4'd0;
      att_r    <= 4'd0;
      pulse_r  <= 5'd0;
      caddr_r  <= 7'd0;
      crd_r    <= 1'b0;
      ckeep_r  <= 1'b0;
      clen_r   <= '0;
      dscl_r   <= 1'b1;
      dsda_r   <= 1'b1;
      fail_r   <= 1'b0;
    end else begin
      phase_r  <= phase_nxt;
      load_r   <= load_nxt;
      shift_r  <= shift_nxt;
      bitc_r   <= bitc_nxt;
      pos_r    <= pos_nxt;
      waitc_r  <= waitc_nxt;
      pausec_r <= pausec_nxt;
      att_r    <= att_nxt;
      pulse_r  <= pulse_nxt;
      caddr_r  <= caddr_nxt;
      crd_r    <= crd_nxt;
      ckeep_r  <= ckeep_nxt;
      clen_r   <= clen_nxt;
      dscl_r   <= dscl_nxt;
      dsda_r   <= dsda_nxt;
      fail_r   <= fail_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else if (adv) begin
      ov_r <= 1'b1;
    end else if (!out_stall) begin
      ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_scl_drive  <= dscl_nxt;
      out_sda_drive  <= dsda_nxt;
      out_read_byte  <= r_byte;
      out_read_valid <= r_valid;
      out_read_index <= r_index;
      out_done_res   <= r_done;
      out_status     <= r_status;
      out_busy_res   <= phase_nxt != i2cm_pkg::PH_IDLE;
    end
  end

  assign out_valid = ov_r;

  a_idle_lines: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_done_res && out_status == i2cm_pkg::ST_FAILED) |-> !out_busy_res)
    else $error("failed transfer left busy");
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (iv_r && ov_r && out_stall) |=> iv_r)
    else $error("input word dropped under stall");
  a_pos_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= CW'(MAX_LEN))
    else $error("byte position past buffer");
  a_read_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_read_valid) |-> (out_status == i2cm_pkg::ST_OK))
    else $error("read byte with error status");
endmodule
